// ===== src/i2cseq_pkg.sv =====
// Package for the I2C master transaction sequencer.
// Holds status codes, action codes, phase codes and the item and result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

  // Command codes
  localparam logic [1:0] CMD_BEGIN_RD = 2'd0;
  localparam logic [1:0] CMD_BEGIN_WR = 2'd1;
  localparam logic [1:0] CMD_WR_BYTE  = 2'd2;
  localparam logic [1:0] CMD_STATUS   = 2'd3;

  // Byte engine status codes
  localparam logic [7:0] ST_STARTED    = 8'h08;
  localparam logic [7:0] ST_REPSTART   = 8'h10;
  localparam logic [7:0] ST_ADDRACK_W  = 8'h18;
  localparam logic [7:0] ST_DATAACK_W  = 8'h28;
  localparam logic [7:0] ST_DATANACK_W = 8'h30;
  localparam logic [7:0] ST_ADDRACK_R  = 8'h40;
  localparam logic [7:0] ST_DATAACK_R  = 8'h50;
  localparam logic [7:0] ST_DATANACK_R = 8'h58;

  // Direction bit appended to the slave address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  // Engine actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_RDACK = 3'd3;
  localparam logic [2:0] ACT_RDNAK = 3'd4;
  localparam logic [2:0] ACT_STOP  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_ENABLED    = 1'b1;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_R_START   = 4'd1;
  localparam logic [3:0] PH_R_ADDRW   = 4'd2;
  localparam logic [3:0] PH_R_REG     = 4'd3;
  localparam logic [3:0] PH_R_RESTART = 4'd4;
  localparam logic [3:0] PH_R_ADDRR   = 4'd5;
  localparam logic [3:0] PH_R_DATA    = 4'd6;
  localparam logic [3:0] PH_W_START   = 4'd7;
  localparam logic [3:0] PH_W_ADDR    = 4'd8;
  localparam logic [3:0] PH_W_NEED    = 4'd9;
  localparam logic [3:0] PH_W_DATA    = 4'd10;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] length;
    logic [7:0] sub_addr;
    logic [7:0] data_byte;
    logic [7:0] status;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       need_data;
    logic       done_res;
    logic [7:0] byte_count;
  } result_t;

  typedef struct packed {
    logic [6:0] slave_address;
    logic       enabled;
  } cfg_t;

endpackage : i2cseq_pkg

`default_nettype wire

// ===== src/i2cseq_fsm.sv =====
// Transaction state machine: phase and counters, one step per transaction.
// Depends on i2cseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_fsm
  import i2cseq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  input  wire cfg_t    cfg_i,
  output result_t      res_o
);

  logic [3:0] phase_q, phase_d;
  logic [7:0] remaining_q, remaining_d;
  logic [7:0] transferred_q, transferred_d;
  logic [7:0] sub_addr_q, sub_addr_d;

  logic [7:0] rem_dec;
  logic [7:0] xfer_inc;
  logic [7:0] addr_w;
  logic [7:0] addr_r;

  assign rem_dec  = remaining_q - 8'd1;
  assign xfer_inc = transferred_q + 8'd1;
  assign addr_w   = {cfg_i.slave_address, RW_WRITE};
  assign addr_r   = {cfg_i.slave_address, RW_READ};

  always_comb begin
    phase_d       = phase_q;
    remaining_d   = remaining_q;
    transferred_d = transferred_q;
    sub_addr_d    = sub_addr_q;
    res_o         = '0;

    if (item_i.cmd == CMD_BEGIN_RD || item_i.cmd == CMD_BEGIN_WR) begin
      if (phase_q == PH_IDLE) begin
        if (!cfg_i.enabled) begin
          res_o.done_res = 1'b1;
        end else begin
          remaining_d   = item_i.length;
          transferred_d = '0;
          res_o.action  = ACT_START;
          if (item_i.cmd == CMD_BEGIN_RD) begin
            sub_addr_d = item_i.sub_addr;
            phase_d    = PH_R_START;
          end else begin
            phase_d    = PH_W_START;
          end
        end
      end
    end else if (item_i.cmd == CMD_WR_BYTE) begin
      if (phase_q == PH_W_NEED) begin
        res_o.action  = ACT_SEND;
        res_o.tx_byte = item_i.data_byte;
        phase_d       = PH_W_DATA;
      end
    end else begin
      unique case (phase_q)
        PH_R_START, PH_W_START: begin
          if (item_i.status == ST_STARTED) begin
            res_o.action  = ACT_SEND;
            res_o.tx_byte = addr_w;
            phase_d       = (phase_q == PH_R_START) ? PH_R_ADDRW : PH_W_ADDR;
          end else begin
            res_o.action = ACT_STOP;
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_R_ADDRW: begin
          if (item_i.status == ST_ADDRACK_W) begin
            res_o.action  = ACT_SEND;
            res_o.tx_byte = sub_addr_q;
            phase_d       = PH_R_REG;
          end else begin
            res_o.action = ACT_STOP;
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_R_REG: begin
          if (item_i.status == ST_DATAACK_W) begin
            res_o.action = ACT_START;
            phase_d      = PH_R_RESTART;
          end else begin
            res_o.action = ACT_STOP;
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_R_RESTART: begin
          if (item_i.status == ST_REPSTART) begin
            res_o.action  = ACT_SEND;
            res_o.tx_byte = addr_r;
            phase_d       = PH_R_ADDRR;
          end else begin
            res_o.action = ACT_STOP;
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_R_ADDRR: begin
          if (item_i.status == ST_ADDRACK_R && remaining_q != '0) begin
            res_o.action = (remaining_q == 8'd1) ? ACT_RDNAK : ACT_RDACK;
            phase_d      = PH_R_DATA;
          end else begin
            res_o.action = ACT_STOP;
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_R_DATA: begin
          if (item_i.status == ST_DATAACK_R || item_i.status == ST_DATANACK_R) begin
            res_o.rx_valid = 1'b1;
            res_o.rx_data  = item_i.rx_byte;
            transferred_d  = xfer_inc;
            remaining_d    = rem_dec;
            if (item_i.status == ST_DATANACK_R || rem_dec == '0) begin
              res_o.action     = ACT_STOP;
              res_o.done_res   = 1'b1;
              res_o.byte_count = xfer_inc;
              phase_d          = PH_IDLE;
            end else begin
              res_o.action = (rem_dec == 8'd1) ? ACT_RDNAK : ACT_RDACK;
            end
          end else begin
            res_o.action     = ACT_STOP;
            res_o.done_res   = 1'b1;
            res_o.byte_count = transferred_q;
            phase_d          = PH_IDLE;
          end
        end
        PH_W_ADDR: begin
          if (item_i.status == ST_ADDRACK_W && remaining_q != '0) begin
            res_o.need_data = 1'b1;
            phase_d         = PH_W_NEED;
          end else begin
            res_o.action = ACT_STOP;
            res_o.done_res = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_W_DATA: begin
          if (item_i.status == ST_DATAACK_W) begin
            transferred_d = xfer_inc;
            remaining_d   = rem_dec;
            if (rem_dec == '0) begin
              res_o.action     = ACT_STOP;
              res_o.done_res   = 1'b1;
              res_o.byte_count = xfer_inc;
              phase_d          = PH_IDLE;
            end else begin
              res_o.need_data = 1'b1;
              phase_d         = PH_W_NEED;
            end
          end else if (item_i.status == ST_DATANACK_W) begin
            transferred_d    = xfer_inc;
            res_o.action     = ACT_STOP;
            res_o.done_res   = 1'b1;
            res_o.byte_count = xfer_inc;
            phase_d          = PH_IDLE;
          end else begin
            res_o.action     = ACT_STOP;
            res_o.done_res   = 1'b1;
            res_o.byte_count = transferred_q;
            phase_d          = PH_IDLE;
          end
        end
        default: begin
          // idle and waiting for a write byte: status is ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      remaining_q   <= '0;
      transferred_q <= '0;
      sub_addr_q    <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      remaining_q   <= remaining_d;
      transferred_q <= transferred_d;
      sub_addr_q    <= sub_addr_d;
    end
  end

endmodule : i2cseq_fsm

`default_nettype wire

// ===== src/i2c_master_transaction_sequencer.sv =====
// A transaction moves from the input register to the result register (out_valid_o) when that
// is empty or draining. Throughput: one transaction per cycle unless out_ready_i stalls; the input
// and result registers form a two-stage pipeline; the state machine steps as one leaves stage one.
// Reset (rst_ni, async, active low) clears phase, counters, config and both valid flags.
// Top level; depends on i2cseq_pkg and i2cseq_fsm.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer
  import i2cseq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration writes
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  // input transactions
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] length_i,
  input  wire logic [7:0] sub_addr_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [7:0] status_i,
  input  wire logic [7:0] rx_byte_i,
  // result transactions
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      action_o,
  output logic [7:0]      tx_byte_o,
  output logic            rx_valid_o,
  output logic [7:0]      rx_data_o,
  output logic            need_data_o,
  output logic            done_res_o,
  output logic [7:0]      byte_count_o
);

  // Configuration registers; the user must write them only while the block is idle (not enforced).
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLAVE_ADDR: cfg_q.slave_address <= cfg_data_i;
        CFG_ENABLED:    cfg_q.enabled       <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: input register.
  logic  s1_valid_q;
  item_t s1_item_q;
  logic  s1_adv;
  logic  in_fire;

  // Stage two: result register.
  logic    out_valid_q;
  result_t out_res_q;
  result_t step_res;

  // Stage one moves on when the result register is empty or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{cmd: cmd_i, length: length_i, sub_addr: sub_addr_i,
                     data_byte: data_byte_i, status: status_i, rx_byte: rx_byte_i};
    end
  end

  // The state machine steps exactly when a transaction crosses into the result register,
  // so the next transaction in stage one always sees the updated phase.
  i2cseq_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_res_q.action;
  assign tx_byte_o    = out_res_q.tx_byte;
  assign rx_valid_o   = out_res_q.rx_valid;
  assign rx_data_o    = out_res_q.rx_data;
  assign need_data_o  = out_res_q.need_data;
  assign done_res_o   = out_res_q.done_res;
  assign byte_count_o = out_res_q.byte_count;

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A finish without a stop (disabled begin) never reports bytes.
  a_disabled_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && action_o == ACT_NONE |-> byte_count_o == 8'd0)
    else $error("nonzero count without stop");

  // A received byte comes with the next read or with the stop.
  a_rx_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |->
      (action_o == ACT_RDACK || action_o == ACT_RDNAK || action_o == ACT_STOP))
    else $error("received byte with unexpected action");

  // A byte request stands alone: no action and no finish.
  a_need_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && need_data_o |-> action_o == ACT_NONE && !done_res_o)
    else $error("byte request mixed with action or finish");

  // tx_byte is only driven with a send.
  a_tx_only_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_SEND |-> tx_byte_o == 8'd0)
    else $error("tx_byte set without send");

endmodule : i2c_master_transaction_sequencer

`default_nettype wire
